/* hdl/fsmf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_pkg
// shared types and constants of the first substring match finder
// ----------------------------------------------------------------------------
package fsmf_pkg;

   localparam int MAX_NEEDLE   = 32;
   localparam int NEEDLE_WORDS = 4;
   localparam int NEEDLE_BYTES = NEEDLE_WORDS * 8;
   localparam int NEEDLE_BITS  = NEEDLE_BYTES * 8;
   localparam int NB_IDX_W     = $clog2(NEEDLE_BYTES);
   localparam int LEN_W        = 6;
   localparam int COUNT_W      = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD_3 = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
   } fsmf_req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] match_start;
   } fsmf_rsp_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } fsmf_qstat_type;

   // needle byte j; bytes past the needle registers read as zero
   function automatic logic [7:0] needle_byte(input logic [NEEDLE_BITS-1:0] needle,
                                              input logic [LEN_W-1:0]       j);
      logic [7:0] b;
      b = 8'h00;
      if (int'(j) < NEEDLE_BYTES) begin
         b = needle[8*j[NB_IDX_W-1:0] +: 8];
      end
      return b;
   endfunction

endpackage
`default_nettype wire

/* hdl/fsmf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_front
// takes text beats, shifts the window, compares with the needle, classifies
// ----------------------------------------------------------------------------
module fsmf_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire fsmf_pkg::fsmf_req_type             req,
   input  wire logic [fsmf_pkg::LEN_W-1:0]         needle_length,
   input  wire logic [fsmf_pkg::NEEDLE_BITS-1:0]   needle,
   output logic                                    push,
   output fsmf_pkg::fsmf_rsp_type                  push_data
);
   import fsmf_pkg::*;

   logic [7:0]         window_ff [MAX_NEEDLE];
   logic [7:0]         window_in [MAX_NEEDLE];
   logic [COUNT_W-1:0] seen_ff;
   logic [COUNT_W-1:0] seen_in;
   logic [COUNT_W-1:0] seen_next;
   logic               reported_ff;
   logic               reported_in;
   logic [MAX_NEEDLE-1:0] byte_ok;
   logic               len_ok;
   logic               hit;

   always_comb begin
      window_in[0] = req.text_byte;
      for (int i = 1; i < MAX_NEEDLE; i++) begin
         window_in[i] = window_ff[i-1];
      end
      seen_next = (seen_ff == {COUNT_W{1'b1}}) ? seen_ff : seen_ff + 1'b1;
   end

   // window position p lines up with needle byte length-1-p
   always_comb begin
      logic [LEN_W-1:0] idx;
      for (int p = 0; p < MAX_NEEDLE; p++) begin
         idx = needle_length - LEN_W'(p) - 1'b1;
         if (LEN_W'(p) < needle_length) begin
            byte_ok[p] = (window_in[p] == needle_byte(needle, idx));
         end else begin
            byte_ok[p] = 1'b1;
         end
      end
   end

   assign len_ok = (needle_length != '0) && (int'(needle_length) <= MAX_NEEDLE) &&
                   (seen_next >= COUNT_W'(needle_length));
   assign hit    = len_ok && (&byte_ok);

   always_comb begin
      push                  = 1'b0;
      push_data.found       = 1'b0;
      push_data.match_start = '0;
      if (accept && !reported_ff) begin
         if (hit) begin
            push                  = 1'b1;
            push_data.found       = 1'b1;
            push_data.match_start = seen_next - COUNT_W'(needle_length);
         end else if (req.is_final) begin
            push = 1'b1;
         end
      end
      seen_in     = req.is_final ? '0   : seen_next;
      reported_in = req.is_final ? 1'b0 : (reported_ff | hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else if (accept) begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/fsmf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_queue
// short result queue between the front and the back
// ----------------------------------------------------------------------------
module fsmf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire fsmf_pkg::fsmf_rsp_type    push_data,
   input  wire logic                      pop,
   output fsmf_pkg::fsmf_rsp_type         head,
   output fsmf_pkg::fsmf_qstat_type       stat
);
   import fsmf_pkg::*;

   fsmf_rsp_type      mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push;
   logic              do_pop;

   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign head           = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/fsmf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_back
// result output register, drains the queue toward the result channel
// ----------------------------------------------------------------------------
module fsmf_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fsmf_pkg::fsmf_qstat_type  stat,
   input  wire fsmf_pkg::fsmf_rsp_type    head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output fsmf_pkg::fsmf_rsp_type         rsp_data
);
   import fsmf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   fsmf_rsp_type data_ff;

   assign pop       = stat.not_empty && (!valid_ff || !rsp_stall);
   assign valid_in  = pop || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

endmodule
`default_nettype wire

/* hdl/first_substring_match_finder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_substring_match_finder
// streaming search for the first occurrence of a needle in a byte stream
// ----------------------------------------------------------------------------
// usage:
//   csr_*  : register writes (index 0 needle length, 1..4 needle words);
//            csr_ready is always high, write only while the block is idle
//   req_*  : one text byte per beat, is_final flags the last byte of a text
//   rsp_*  : at most one result per text: found with the start offset of the
//            first match, or not found when the final byte ends a text
// timing:
//   a byte is compared in the cycle it is accepted; its result passes the queue and
//   the output register to rsp_*; one byte per cycle sustained while req_stall is low
// stall:
//   results wait in a 4-entry queue plus the output register; req_stall
//   rises only when that queue is full
// reset:
//   needle length and needle words clear, offset count and report flag clear
// ----------------------------------------------------------------------------
module first_substring_match_finder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire fsmf_pkg::fsmf_req_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output fsmf_pkg::fsmf_rsp_type                   rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fsmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fsmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsmf_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]       needle_length_ff;
   logic [NEEDLE_BITS-1:0] needle_ff;
   logic                   csr_fire;

   // front / queue / back hookup
   logic           req_fire;
   logic           push;
   fsmf_rsp_type   push_data;
   logic           pop;
   fsmf_rsp_type   head;
   fsmf_qstat_type qstat;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // out-of-range indexes fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         needle_ff        <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_NEEDLE_WORD_0: needle_ff[0*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_NEEDLE_WORD_1: needle_ff[1*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_NEEDLE_WORD_2: needle_ff[2*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            CSR_NEEDLE_WORD_3: needle_ff[3*CSR_DATA_W +: CSR_DATA_W] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stall only on a full queue, so a result never has nowhere to go
   assign req_stall = qstat.full;
   assign req_fire  = req_valid && !req_stall;

   fsmf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_fire),
      .req           (req_data),
      .needle_length (needle_length_ff),
      .needle        (needle_ff),
      .push          (push),
      .push_data     (push_data)
   );

   fsmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   fsmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stat      (qstat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a result is never pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("result pushed into full queue");

   // a popped entry shows up on the result channel next cycle
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped result not presented");

   // a not-found result carries a zero offset
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (push && !push_data.found) |-> (push_data.match_start == '0))
      else $error("not-found result with nonzero offset");

   // an empty queue with no pending output leaves the result channel idle
   a_idle_out: assert property (@(posedge clock) disable iff (reset)
      (!qstat.not_empty && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared from nothing");

endmodule
`default_nettype wire

/* test/first_substring_match_finder_tb.sv */
// ----------------------------------------------------------------------------
// first_substring_match_finder_tb
// Self-checking bench for the streaming first-match search. A scoreboard
// class mirrors the needle registers and the per-text window and count,
// predicts the found / not found result of every accepted text byte, and
// checks each result beat in order. Stimulus is a directed opening followed
// by random phases, each with its own needle setting, made mostly of texts
// that carry the needle, broken copies of it, or bytes from a small
// alphabet. Both sides idle at random.
// ----------------------------------------------------------------------------
module first_substring_match_finder_tb;
   import fsmf_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 3;
   localparam int IDLE_PCT       = 22;
   localparam int SETTLE_CYCLES  = 4;     // a result passes the queue and the output register after accept
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any port
   localparam int RANDOM_ITEMS   = 1000;
   localparam int BURST_ITEMS    = 40;
   localparam int MAX_LEN_CODE   = (1 << LEN_W) - 1;

   // first index past the needle registers, ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_NEEDLE_WORD_3 + 1'b1;

   // needle fill styles
   typedef enum int {
      NEEDLE_RANDOM,
      NEEDLE_POOL,
      NEEDLE_ZEROS,
      NEEDLE_ONES
   } needle_style_type;

   // -------------------------------------------------------------------------
   // scoreboard: mirror of the search state plus the queue of expected results
   // -------------------------------------------------------------------------
   class match_scoreboard;
      logic [LEN_W-1:0]   needle_len;
      logic [7:0]         needle [NEEDLE_BYTES];
      logic [7:0]         window [MAX_NEEDLE];   // newest byte at index 0
      logic [COUNT_W-1:0] seen;
      bit                 reported;
      fsmf_rsp_type       expected_hits [$];
      int                 errors;
      int                 results;
      int                 hits;

      function new();
         needle_len = '0;
         foreach (needle[j]) needle[j] = 8'h00;
         clear_text();
         errors  = 0;
         results = 0;
         hits    = 0;
      endfunction

      function void clear_text();
         foreach (window[k]) window[k] = 8'h00;
         seen     = '0;
         reported = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         int base;
         base = 8 * (int'(idx) - int'(CSR_NEEDLE_WORD_0));
         case (idx)
            CSR_NEEDLE_LENGTH: needle_len = val[LEN_W-1:0];
            CSR_NEEDLE_WORD_0, CSR_NEEDLE_WORD_1, CSR_NEEDLE_WORD_2,
            CSR_NEEDLE_WORD_3: begin
               for (int b = 0; b < 8; b++) needle[base + b] = val[8*b +: 8];
            end
            default: ;   // unused index, no effect
         endcase
      endfunction

      // shift one text byte in and queue the result it causes, if any
      function void note_byte(fsmf_req_type beat);
         bit           hit;
         int           n;
         logic [7:0]   nb;
         fsmf_rsp_type e;
         for (int k = MAX_NEEDLE - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = beat.text_byte;
         if (seen != '1) seen++;   // count saturates

         // empty needle and needle longer than the window never match
         n   = int'(needle_len);
         hit = (n != 0) && (n <= MAX_NEEDLE) && (seen >= COUNT_W'(n));
         if (hit) begin
            for (int j = 0; j < n; j++) begin
               nb = (j < NEEDLE_BYTES) ? needle[j] : 8'h00;
               if (window[n-1-j] != nb) hit = 1'b0;
            end
         end

         if (!reported) begin
            if (hit) begin
               reported      = 1'b1;
               e.found       = 1'b1;
               e.match_start = seen - COUNT_W'(n);
               expected_hits.push_back(e);
            end else if (beat.is_final) begin
               e = '0;
               expected_hits.push_back(e);
            end
         end
         if (beat.is_final) clear_text();
      endfunction

      function void check_result(fsmf_rsp_type got);
         fsmf_rsp_type e;
         results++;
         if (got.found === 1'b1) hits++;
         if (expected_hits.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual found=%0b start=%0d",
                     $time, got.found, got.match_start);
            return;
         end
         e = expected_hits.pop_front();
         if (got.found !== e.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, got.found);
         end
         if (got.match_start !== e.match_start) begin
            errors++;
            $display("%0t: match_start mismatch, expected %0d actual %0d",
                     $time, e.match_start, got.match_start);
         end
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // block inputs, all driven to known values from time zero
   // -------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   fsmf_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   fsmf_rsp_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   first_substring_match_finder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   match_scoreboard sb;

   // stimulus side state
   logic [7:0] stim_needle [NEEDLE_BYTES];
   logic [7:0] alpha [4];          // small alphabet for dense partial matches
   int         cur_len    = 0;
   int         bytes_sent = 0;
   int         settings   = 0;
   bit         tx_quiet   = 1'b0;  // sender never idles while set
   logic       rx_quiet   = 1'b0;  // receiver never idles while set
   int         hold_req   = 0;     // bumped by the stimulus to ask for a hold-off
   int         hold_seen  = 0;
   int         hold_left  = 0;
   int         dead_cycles = 0;

   // -------------------------------------------------------------------------
   // receiver: checks each result beat, stalls at random or for a long hold
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_result(rsp_data);
      end
      if (hold_seen != hold_req) begin
         // start of the long hold-off, counted here
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !rx_quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // -------------------------------------------------------------------------
   // watchdog: ends the run after too many cycles with no beat anywhere
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         dead_cycles <= 0;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
      if (dead_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
         $display("first_substring_match_finder verification failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // driver tasks
   // -------------------------------------------------------------------------

   // one text beat; valid stays high into the next beat when there is no gap
   task automatic send_byte(input logic [7:0] b, input logic fin);
      fsmf_req_type beat;
      while (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      beat.text_byte = b;
      beat.is_final  = fin;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(beat);
      bytes_sent++;
   endtask

   // csr_valid is left high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, val);
   endtask

   // sender pauses until every expected result is in, then lets the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all needle registers from stim_needle, sometimes an unused index too
   task automatic program_needle(input int len);
      logic [CSR_DATA_W-1:0] w;
      logic [CSR_DATA_W-1:0] lenw;
      wait_drained();
      cur_len = len;
      lenw = {$urandom, $urandom};   // upper bits are don't-care for the block
      lenw[LEN_W-1:0] = LEN_W'(len);
      write_csr(CSR_NEEDLE_LENGTH, lenw);
      for (int k = 0; k < NEEDLE_WORDS; k++) begin
         for (int b = 0; b < 8; b++) w[8*b +: 8] = stim_needle[8*k + b];
         write_csr(CSR_IDX_W'(int'(CSR_NEEDLE_WORD_0) + k), w);
      end
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_IDX_W'(int'(CSR_FIRST_UNUSED) + $urandom_range(0, 2)),
                   {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   // fill stim_needle and the matching alphabet
   task automatic pick_needle(input int len, input needle_style_type style);
      logic [7:0] pool [3];
      foreach (pool[p]) pool[p] = 8'($urandom_range(0, 255));
      foreach (stim_needle[j]) begin
         case (style)
            NEEDLE_POOL:  stim_needle[j] = pool[$urandom_range(0, 2)];
            NEEDLE_ZEROS: stim_needle[j] = 8'h00;
            NEEDLE_ONES:  stim_needle[j] = 8'hFF;
            default:      stim_needle[j] = 8'($urandom_range(0, 255));
         endcase
      end
      for (int a = 0; a < 3; a++) begin
         alpha[a] = (len >= 1 && len <= MAX_NEEDLE) ? stim_needle[$urandom_range(0, len - 1)]
                                                   : 8'($urandom_range(0, 255));
      end
      alpha[3] = 8'($urandom_range(0, 255));
   endtask

   // one text: needle planted, broken copy, alphabet soup or pure noise
   task automatic send_haystack(input bit finish);
      int         hl;
      int         pos;
      int         mode;
      bit         fits;
      logic [7:0] text [$];
      fits = (cur_len >= 1 && cur_len <= MAX_NEEDLE);
      mode = $urandom_range(0, 99);
      if (fits) begin
         hl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_len)
                                           : cur_len + $urandom_range(0, 16);
      end else begin
         hl = $urandom_range(1, 20);
      end
      for (int i = 0; i < hl; i++) begin
         text.push_back((mode < 15) ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)]);
      end
      if (fits && hl >= cur_len && mode >= 15 && mode < 75) begin
         pos = $urandom_range(0, hl - cur_len);
         for (int j = 0; j < cur_len; j++) text[pos + j] = stim_needle[j];
      end else if (fits && cur_len >= 2 && hl >= cur_len && mode >= 75 && mode < 90) begin
         // needle with its last byte spoiled
         pos = $urandom_range(0, hl - cur_len);
         for (int j = 0; j < cur_len - 1; j++) text[pos + j] = stim_needle[j];
         text[pos + cur_len - 1] = stim_needle[cur_len - 1] ^ 8'h01;
      end
      for (int i = 0; i < hl; i++) send_byte(text[i], finish && (i == hl - 1));
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      int               ph;
      int               nh;
      int               len;
      int               r;
      int               random_end;
      needle_style_type style;

      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed opening ----

      // empty needle straight out of reset: final byte gives not found
      send_byte(8'h00, 1'b1);

      // one-byte needle, match on the final byte
      foreach (stim_needle[j]) stim_needle[j] = 8'h00;
      stim_needle[0] = 8'hFF;
      program_needle(1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // match first, then a final byte after the report gives nothing
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // needle longer than the window never matches
      pick_needle(MAX_NEEDLE + 8, NEEDLE_RANDOM);
      program_needle(MAX_NEEDLE + 8);
      send_byte(stim_needle[0], 1'b0);
      send_byte(stim_needle[1], 1'b0);
      send_byte(stim_needle[2], 1'b1);

      // needle changed mid-text: the window keeps the byte already seen
      foreach (stim_needle[j]) stim_needle[j] = 8'h00;
      stim_needle[0] = 8'h41;
      stim_needle[1] = 8'h42;
      program_needle(2);
      send_byte(8'h41, 1'b0);
      wait_drained();
      write_csr(CSR_NEEDLE_WORD_0, 64'h0000_0000_0000_4341);
      csr_valid <= 1'b0;
      send_byte(8'h43, 1'b1);

      // writes to unused indexes leave the needle alone
      wait_drained();
      write_csr(CSR_FIRST_UNUSED, {$urandom, $urandom});
      write_csr(CSR_IDX_W'(int'(CSR_FIRST_UNUSED) + 1), 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_IDX_W'(int'(CSR_FIRST_UNUSED) + 2), {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_byte(8'h41, 1'b0);
      send_byte(8'h43, 1'b1);

      // ---- random phases, each with its own needle ----
      random_end = bytes_sent + RANDOM_ITEMS;
      ph = 0;
      while (bytes_sent < random_end) begin
         nh = $urandom_range(3, 8);
         case (ph)
            0: begin len = MAX_NEEDLE;     style = NEEDLE_POOL;   end
            1: begin len = 0;              style = NEEDLE_RANDOM; end
            2: begin len = 1;              style = NEEDLE_ZEROS;  end
            3: begin len = MAX_LEN_CODE;   style = NEEDLE_ONES;   end
            4: begin len = MAX_NEEDLE + 1; style = NEEDLE_POOL;   end
            5: begin len = 8;              style = NEEDLE_ONES;   end
            8: begin len = 1;              style = NEEDLE_RANDOM; end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 45)      len = $urandom_range(1, 4);
               else if (r < 70) len = $urandom_range(5, 12);
               else if (r < 85) len = $urandom_range(13, MAX_NEEDLE);
               else if (r < 93) len = $urandom_range(MAX_NEEDLE + 1, MAX_LEN_CODE);
               else             len = 0;
               r = $urandom_range(0, 99);
               if (r < 50)      style = NEEDLE_POOL;
               else if (r < 85) style = NEEDLE_RANDOM;
               else if (r < 93) style = NEEDLE_ZEROS;
               else             style = NEEDLE_ONES;
            end
         endcase
         pick_needle(len, style);
         program_needle(len);

         // one long stretch with no idling on either side
         tx_quiet = (ph == 1);
         rx_quiet <= (ph == 1);
         if (ph == 1) nh = 12;

         if (ph == 2) begin
            // every byte ends a text, so each beat makes a result; the receiver
            // holds off and the block has to stall its input
            hold_req <= hold_req + 1;
            tx_quiet = 1'b1;
            for (int i = 0; i < BURST_ITEMS; i++) begin
               send_byte(($urandom_range(0, 1) == 0) ? stim_needle[0]
                                                      : 8'($urandom_range(0, 255)), 1'b1);
            end
            tx_quiet = 1'b0;
            wait_drained();
         end

         // the last text of a phase is sometimes left open across the next write
         for (int h = 0; h < nh && bytes_sent < random_end; h++) begin
            send_haystack(!(h == nh - 1 && $urandom_range(0, 4) == 0));
         end
         ph++;
      end

      // close any open text, then drain
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      tx_quiet = 1'b0;
      rx_quiet <= 1'b0;
      wait_drained();

      $display("ran %0d text bytes over %0d needle settings, %0d result beats (%0d found)",
               bytes_sent, settings, sb.results, sb.hits);
      $display("needle lengths 0 to %0d, mid-text needle change, unused indexes, long hold-off",
               MAX_LEN_CODE);
      if (sb.errors == 0) begin
         $display("first_substring_match_finder verification clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("first_substring_match_finder verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/fsmf_pkg.sv
hdl/fsmf_front.sv
hdl/fsmf_queue.sv
hdl/fsmf_back.sv
hdl/first_substring_match_finder.sv
test/first_substring_match_finder_tb.sv
